@@ rtl/core/ppm_shock_flattening_coef_top_defines.svh @@
// Assertion macros shared by the flattening coefficient RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef PPM_SHOCK_FLATTENING_COEF_TOP_DEFINES_SVH
`define PPM_SHOCK_FLATTENING_COEF_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PSFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/psfc_pkg.sv @@
// Package for the PPM shock flattening coefficient block.
// Holds register indexes, reset values and fixed widths; no dependencies.
package psfc_pkg;

  localparam int ZETA_BITS = 18;
  localparam int ZETA_FRAC = 16;
  localparam int THR_W     = 16;
  localparam int ZLIM_W    = 18;
  localparam int CFG_ADDR_W = 4;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_SHOCK_THRESHOLD = 2'd0;
  localparam reg_idx_t REG_ZETA_LOW        = 2'd1;
  localparam reg_idx_t REG_ZETA_HIGH       = 2'd2;

  localparam logic [THR_W-1:0]  THR_RESET   = 16'd21627;
  localparam logic [ZLIM_W-1:0] ZLOW_RESET  = 18'd49152;
  localparam logic [ZLIM_W-1:0] ZHIGH_RESET = 18'd55706;

  // Saturated zeta (4.0 in Q2.16) lies above every programmable zeta_high.
  localparam logic [ZETA_BITS:0] ZETA_SAT = 19'h40000;

endpackage

@@ rtl/core/ppm_shock_flattening_coef_top.sv @@
// Top level of the PPM shock flattening coefficient pipeline.
// Depends on psfc_pkg and ppm_shock_flattening_coef_top_defines.svh.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | 7 pressures, 5 velocities
//  out_    | output    | out_valid/out_stall| flatten_coef
//  cfg     | input     | APB psel/penable   | 3 registers at 0x0, 0x4, 0x8
//
// One word enters per cycle while the output is not stalled; the restoring dividers
// retire one quotient bit per stage (zeta, then ramp).
// Reset is synchronous, active low, and clears valid bits and configuration registers.
// A stall on a valid output word freezes every stage at once and asserts in_stall.
`include "ppm_shock_flattening_coef_top_defines.svh"

module ppm_shock_flattening_coef_top #(
  parameter int PRESSURE_BITS  = 32,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [31:0]                       in_press_m3,
  input  logic [31:0]                       in_press_m2,
  input  logic [31:0]                       in_press_m1,
  input  logic [31:0]                       in_press_center,
  input  logic [31:0]                       in_press_p1,
  input  logic [31:0]                       in_press_p2,
  input  logic [31:0]                       in_press_p3,
  input  logic signed [31:0]                in_vel_m2,
  input  logic signed [31:0]                in_vel_m1,
  input  logic signed [31:0]                in_vel_center,
  input  logic signed [31:0]                in_vel_p1,
  input  logic signed [31:0]                in_vel_p2,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       out_flatten_coef,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psfc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import psfc_pkg::*;

  localparam int PB  = PRESSURE_BITS;
  localparam int FB  = COEF_FRAC_BITS;
  localparam int RW  = PB + 3;
  localparam int ZB  = ZETA_BITS;
  localparam int NST = 5 + ZB + FB;
  localparam int VD0 = 2;           // stage index of the zeta divider entry
  localparam int VF0 = 3 + ZB;      // stage index of the ramp divider entry
  localparam logic [FB:0] COEF_ONE = {1'b1, {FB{1'b0}}};

  // Configuration registers.
  logic [THR_W-1:0]  thr_r;
  logic [ZLIM_W-1:0] zlow_r;
  logic [ZLIM_W-1:0] zhigh_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      zlow_r  <= ZLOW_RESET;
      zhigh_r <= ZHIGH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SHOCK_THRESHOLD: thr_r   <= pwdata[THR_W-1:0];
        REG_ZETA_LOW:        zlow_r  <= pwdata[ZLIM_W-1:0];
        REG_ZETA_HIGH:       zhigh_r <= pwdata[ZLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SHOCK_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, thr_r};
      REG_ZETA_LOW:        prdata = {{(32-ZLIM_W){1'b0}}, zlow_r};
      REG_ZETA_HIGH:       prdata = {{(32-ZLIM_W){1'b0}}, zhigh_r};
      default:             prdata = '0;
    endcase
  end

  // Pipeline control: every stage moves together.
  logic           pipe_en;
  logic [NST-1:0] vld_r;

  assign pipe_en   = !(vld_r[NST-1] && out_stall);
  assign in_stall  = !pipe_en;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Stage 1: registered stencil.
  logic [PB-1:0]     pr_r [7];
  logic signed [31:0] vr_r [5];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pr_r[0] <= PB'(in_press_m3);
      pr_r[1] <= PB'(in_press_m2);
      pr_r[2] <= PB'(in_press_m1);
      pr_r[3] <= PB'(in_press_center);
      pr_r[4] <= PB'(in_press_p1);
      pr_r[5] <= PB'(in_press_p2);
      pr_r[6] <= PB'(in_press_p3);
      vr_r[0] <= in_vel_m2;
      vr_r[1] <= in_vel_m1;
      vr_r[2] <= in_vel_center;
      vr_r[3] <= in_vel_p1;
      vr_r[4] <= in_vel_p2;
    end
  end

  // Stage 2 operands: cell 0 is the cell itself, cell 1 the upwind neighbor.
  logic              up_left;
  logic [PB-1:0]     pl [2];
  logic [PB-1:0]     pq [2];
  logic [PB-1:0]     wl [2];
  logic [PB-1:0]     wq [2];
  logic signed [31:0] vl [2];
  logic signed [31:0] vq [2];

  assign up_left = pr_r[4] > pr_r[2];

  always_comb begin
    pl[0] = pr_r[2];
    pq[0] = pr_r[4];
    wl[0] = pr_r[1];
    wq[0] = pr_r[5];
    vl[0] = vr_r[1];
    vq[0] = vr_r[3];
    if (up_left) begin
      pl[1] = pr_r[1];
      pq[1] = pr_r[3];
      wl[1] = pr_r[0];
      wq[1] = pr_r[4];
      vl[1] = vr_r[0];
      vq[1] = vr_r[2];
    end else begin
      pl[1] = pr_r[3];
      pq[1] = pr_r[5];
      wl[1] = pr_r[2];
      wq[1] = pr_r[6];
      vl[1] = vr_r[2];
      vq[1] = vr_r[4];
    end
  end

  logic [PB-1:0]       adp2_r  [2];
  logic [PB-1:0]       den2_r  [2];
  logic [PB-1:0]       pmin2_r [2];
  logic                comp2_r [2];
  logic [PB-1:0]       adp3_r  [2];
  logic [PB+THR_W-1:0] prod3_r [2];

  // Zeta divider stages; entry 0 is loaded by stage 3.
  logic [RW-1:0] drem_r [2][ZB+1];
  logic [ZB-1:0] dq_r   [2][ZB+1];
  logic [PB-1:0] dden_r [2][ZB+1];
  logic          dcomp_r[2][ZB+1];
  logic          dbig_r [2][ZB+1];
  logic          dsat_r [2][ZB+1];

  // Ramp divider stages; entry 0 is the setup stage.
  logic [ZLIM_W-1:0] frem_r [2][FB+1];
  logic [FB-1:0]     fq_r   [2][FB+1];
  logic [ZLIM_W-1:0] fw_r   [2][FB+1];
  logic              fone_r [2][FB+1];
  logic              fzero_r[2][FB+1];
  logic              fflag_r[2][FB+1];

  logic [FB:0] s_w [2];

  for (genvar c = 0; c < 2; c++) begin : g_cell
    logic [PB-1:0]      adp_w;
    logic [PB-1:0]      den_w;
    logic signed [32:0] dv_w;

    assign adp_w = (pq[c] >= pl[c]) ? pq[c] - pl[c] : pl[c] - pq[c];
    assign den_w = (wq[c] >= wl[c]) ? wq[c] - wl[c] : wl[c] - wq[c];
    assign dv_w  = {vl[c][31], vl[c]} - {vq[c][31], vq[c]};

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        adp2_r[c]  <= adp_w;
        den2_r[c]  <= (den_w == '0) ? PB'(1) : den_w;
        pmin2_r[c] <= (pl[c] < pq[c]) ? pl[c] : pq[c];
        comp2_r[c] <= !dv_w[32];
      end
    end

    // Stage 3: saturation test, threshold product, divider load.
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        adp3_r[c]     <= adp2_r[c];
        prod3_r[c]    <= thr_r * pmin2_r[c];
        drem_r[c][0]  <= {3'b000, adp2_r[c]};
        dq_r[c][0]    <= '0;
        dden_r[c][0]  <= den2_r[c];
        dcomp_r[c][0] <= comp2_r[c];
        dbig_r[c][0]  <= 1'b0;
        dsat_r[c][0]  <= {2'b00, adp2_r[c]} >= {den2_r[c], 2'b00};
      end
    end

    // Each stage doubles the remainder and compares with four times den,
    // so after ZB stages the quotient is adp * 2^16 / den.
    for (genvar j = 1; j <= ZB; j++) begin : g_zdiv
      logic [RW-1:0] t_w;
      logic [RW-1:0] d4_w;
      logic          ge_w;

      assign t_w  = {drem_r[c][j-1][RW-2:0], 1'b0};
      assign d4_w = {1'b0, dden_r[c][j-1], 2'b00};
      assign ge_w = t_w >= d4_w;

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          drem_r[c][j]  <= ge_w ? t_w - d4_w : t_w;
          dq_r[c][j]    <= {dq_r[c][j-1][ZB-2:0], ge_w};
          dden_r[c][j]  <= dden_r[c][j-1];
          dcomp_r[c][j] <= dcomp_r[c][j-1];
          dsat_r[c][j]  <= dsat_r[c][j-1];
          if (j == 1) begin
            dbig_r[c][j] <= {adp3_r[c], {ZETA_FRAC{1'b0}}} > prod3_r[c];
          end else begin
            dbig_r[c][j] <= dbig_r[c][j-1];
          end
        end
      end
    end

    // Ramp setup: clamp cases and the divider operands.
    logic [ZB:0] zeta_w;
    logic        one_w;

    assign zeta_w = dsat_r[c][ZB] ? ZETA_SAT : {1'b0, dq_r[c][ZB]};
    assign one_w  = zeta_w >= {1'b0, zhigh_r};

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        fone_r[c][0]  <= one_w;
        fzero_r[c][0] <= (zhigh_r <= zlow_r) ? !one_w : (zeta_w <= {1'b0, zlow_r});
        fflag_r[c][0] <= dcomp_r[c][ZB] && dbig_r[c][ZB];
        frem_r[c][0]  <= ZLIM_W'(zeta_w - {1'b0, zlow_r});
        fw_r[c][0]    <= zhigh_r - zlow_r;
        fq_r[c][0]    <= '0;
      end
    end

    for (genvar j = 1; j <= FB; j++) begin : g_rdiv
      logic [ZLIM_W:0] t_w;
      logic            ge_w;

      assign t_w  = {frem_r[c][j-1], 1'b0};
      assign ge_w = t_w >= {1'b0, fw_r[c][j-1]};

      always_ff @(posedge clk) begin
        if (pipe_en) begin
          frem_r[c][j]  <= ge_w ? ZLIM_W'(t_w - {1'b0, fw_r[c][j-1]})
                                : ZLIM_W'(t_w);
          if (j == 1) begin
            fq_r[c][j] <= FB'(ge_w);
          end else begin
            fq_r[c][j] <= {fq_r[c][j-1][FB-2:0], ge_w};
          end
          fw_r[c][j]    <= fw_r[c][j-1];
          fone_r[c][j]  <= fone_r[c][j-1];
          fzero_r[c][j] <= fzero_r[c][j-1];
          fflag_r[c][j] <= fflag_r[c][j-1];
        end
      end
    end

    logic [FB:0] z_w;

    always_comb begin
      priority if (fone_r[c][FB]) begin
        z_w = COEF_ONE;
      end else if (fzero_r[c][FB]) begin
        z_w = '0;
      end else begin
        z_w = {1'b0, fq_r[c][FB]};
      end
    end

    assign s_w[c] = fflag_r[c][FB] ? z_w : '0;
  end

  // Output stage.
  logic [FB:0] coef_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      coef_r <= COEF_ONE - ((s_w[0] > s_w[1]) ? s_w[0] : s_w[1]);
    end
  end

  assign out_flatten_coef = 16'(coef_r);

  `PSFC_ASSERT_NEXT(a_stall_freezes, !pipe_en, vld_r == $past(vld_r), "pipeline moved under stall")
  `PSFC_ASSERT_NOW(a_coef_bound, out_valid, coef_r <= COEF_ONE, "coefficient above one")
  `PSFC_ASSERT_NOW(a_ramp_ends, vld_r[VF0], !(fone_r[0][0] && fzero_r[0][0]) && !(fone_r[1][0] && fzero_r[1][0]), "ramp both full and empty")
  `PSFC_ASSERT_NOW(a_sat_entry, vld_r[VD0] && dsat_r[0][0], adp3_r[0] >= dden_r[0][0], "saturation without large jump")

endmodule
